// File: rtl/core/rwo_pkg.sv
// Shared constants and types for the window overlap test.
package rwo_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int WIN_LO_RST     = -4096;
    localparam int WIN_HI_RST     = 4096;
    localparam int CFG_IDX_W      = 2;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_X_MIN = 2'd0,
        CFG_X_MAX = 2'd1,
        CFG_Y_MIN = 2'd2,
        CFG_Y_MAX = 2'd3
    } t_cfg_reg;

    typedef struct packed {
        logic prod;
        logic dot;
        logic span;
    } t_span_en;

endpackage

// File: rtl/core/rwo_axis_span.sv
// Projection of both shapes onto one axis and the interval overlap check.
module rwo_axis_span #(
    parameter int COORD_BITS = rwo_pkg::COORD_BITS_DEF
) (
    input  logic                         i_clk,
    input  rwo_pkg::t_span_en            i_en,
    input  logic signed [COORD_BITS-1:0] i_px [8],
    input  logic signed [COORD_BITS-1:0] i_py [8],
    input  logic signed [COORD_BITS:0]   i_ax,
    input  logic signed [COORD_BITS:0]   i_ay,
    output logic                         o_overlap
);

    localparam int PW = 2 * COORD_BITS + 1;
    localparam int DW = 2 * COORD_BITS + 2;

    logic signed [PW-1:0] r_prod_x [8];
    logic signed [PW-1:0] r_prod_y [8];
    logic signed [DW-1:0] r_dot [8];
    logic signed [DW-1:0] r_lo [2];
    logic signed [DW-1:0] r_hi [2];
    logic signed [DW-1:0] n_lo [2];
    logic signed [DW-1:0] n_hi [2];

    always_ff @(posedge i_clk) begin
        for (int i = 0; i < 8; i++) begin
            if (i_en.prod) begin
                r_prod_x[i] <= PW'(i_px[i]) * PW'(i_ax);
                r_prod_y[i] <= PW'(i_py[i]) * PW'(i_ay);
            end
            if (i_en.dot) begin
                r_dot[i] <= DW'(r_prod_x[i]) + DW'(r_prod_y[i]);
            end
        end
        if (i_en.span) begin
            r_lo <= n_lo;
            r_hi <= n_hi;
        end
    end

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            n_lo[s] = r_dot[4*s];
            n_hi[s] = r_dot[4*s];
            for (int k = 1; k < 4; k++) begin
                if (r_dot[4*s+k] < n_lo[s]) begin
                    n_lo[s] = r_dot[4*s+k];
                end
                if (r_dot[4*s+k] > n_hi[s]) begin
                    n_hi[s] = r_dot[4*s+k];
                end
            end
        end
    end

    assign o_overlap = (r_hi[0] >= r_lo[1]) && (r_hi[1] >= r_lo[0]);

endmodule

// File: rtl/core/rect_window_overlap_sat.sv
// Top level: separating-axis overlap test of a quadrilateral against a window.
//
// Channel   Direction  Payload
// s_axis    in         tdata: 8 corner coordinates, COORD_BITS each
// m_axis    out        tdata[0]: overlaps, rest zero
// i_cfg_*   in         window edges, index 0..3
//
// Six register stages from input to result; one item per cycle when the
// output is taken. The two rectangle-edge axes each use 16 multipliers.
// Reset clears all stage valids, holds tready low and loads the window
// with -4096 .. 4096.
// A stall backs up only through full stages; empty stages keep filling.
module rect_window_overlap_sat #(
    parameter int COORD_BITS = rwo_pkg::COORD_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // lt_x, lt_y, rt_x, rt_y, lb_x, lb_y, rb_x, rb_y
    input  logic [8*COORD_BITS-1:0]       s_axis_tdata,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // overlaps, zero fill
    output logic [7:0]                    m_axis_tdata,
    input  logic                          i_cfg_we,
    input  logic [rwo_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [COORD_BITS-1:0]         i_cfg_data
);

    localparam int NSTG = 6;
    localparam int C    = COORD_BITS;

    logic signed [C-1:0] r_x_min, r_x_max, r_y_min, r_y_max;
    logic [NSTG-1:0]     r_vld;
    logic [NSTG-1:0]     stg_en;

    logic signed [C-1:0] r_s0_x [4];
    logic signed [C-1:0] r_s0_y [4];
    logic signed [C-1:0] r_s1_x [4];
    logic signed [C-1:0] r_s1_y [4];
    logic signed [C:0]   r_a2_x, r_a2_y, r_a3_x, r_a3_y;
    logic                r_ok1, r_ok2, r_ok3, r_ok4;
    logic                r_overlaps;

    logic signed [C:0]   n_a2_x, n_a2_y, n_a3_x, n_a3_y;
    logic signed [C-1:0] rx_lo, rx_hi, ry_lo, ry_hi;
    logic signed [C-1:0] wx_lo, wx_hi, wy_lo, wy_hi;
    logic                n_ok1;

    logic signed [C-1:0] pt_x [8];
    logic signed [C-1:0] pt_y [8];
    logic                ovl2, ovl3;
    rwo_pkg::t_span_en   span_en;

    always_comb begin
        stg_en[NSTG-1] = !r_vld[NSTG-1] || m_axis_tready;
        for (int k = NSTG - 2; k >= 0; k--) begin
            stg_en[k] = !r_vld[k] || stg_en[k+1];
        end
    end

    assign s_axis_tready = stg_en[0] && i_rst_n;
    assign m_axis_tvalid = r_vld[NSTG-1];
    assign m_axis_tdata  = {7'd0, r_overlaps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_x_min <= C'(rwo_pkg::WIN_LO_RST);
            r_x_max <= C'(rwo_pkg::WIN_HI_RST);
            r_y_min <= C'(rwo_pkg::WIN_LO_RST);
            r_y_max <= C'(rwo_pkg::WIN_HI_RST);
        end else begin
            if (stg_en[0]) begin
                r_vld[0] <= s_axis_tvalid;
            end
            for (int k = 1; k < NSTG; k++) begin
                if (stg_en[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
            if (i_cfg_we) begin
                unique case (rwo_pkg::t_cfg_reg'(i_cfg_idx))
                    rwo_pkg::CFG_X_MIN: r_x_min <= i_cfg_data;
                    rwo_pkg::CFG_X_MAX: r_x_max <= i_cfg_data;
                    rwo_pkg::CFG_Y_MIN: r_y_min <= i_cfg_data;
                    rwo_pkg::CFG_Y_MAX: r_y_max <= i_cfg_data;
                    default: ;
                endcase
            end
        end
    end

    // Edge axes and the two window-aligned axes
    always_comb begin
        n_a2_x = (C+1)'(r_s0_x[1]) - (C+1)'(r_s0_x[0]);
        n_a2_y = (C+1)'(r_s0_y[1]) - (C+1)'(r_s0_y[0]);
        n_a3_x = (C+1)'(r_s0_x[1]) - (C+1)'(r_s0_x[3]);
        n_a3_y = (C+1)'(r_s0_y[1]) - (C+1)'(r_s0_y[3]);
        rx_lo  = r_s0_x[0];
        rx_hi  = r_s0_x[0];
        ry_lo  = r_s0_y[0];
        ry_hi  = r_s0_y[0];
        for (int k = 1; k < 4; k++) begin
            if (r_s0_x[k] < rx_lo) rx_lo = r_s0_x[k];
            if (r_s0_x[k] > rx_hi) rx_hi = r_s0_x[k];
            if (r_s0_y[k] < ry_lo) ry_lo = r_s0_y[k];
            if (r_s0_y[k] > ry_hi) ry_hi = r_s0_y[k];
        end
        wx_lo = (r_x_min < r_x_max) ? r_x_min : r_x_max;
        wx_hi = (r_x_min < r_x_max) ? r_x_max : r_x_min;
        wy_lo = (r_y_min < r_y_max) ? r_y_min : r_y_max;
        wy_hi = (r_y_min < r_y_max) ? r_y_max : r_y_min;
        n_ok1 = (r_x_min != r_x_max) && (rx_hi >= wx_lo) && (wx_hi >= rx_lo)
             && (r_y_min != r_y_max) && (ry_hi >= wy_lo) && (wy_hi >= ry_lo)
             && ((n_a2_x != '0) || (n_a2_y != '0))
             && ((n_a3_x != '0) || (n_a3_y != '0));
    end

    always_ff @(posedge i_clk) begin
        if (stg_en[0]) begin
            for (int i = 0; i < 4; i++) begin
                r_s0_x[i] <= s_axis_tdata[(2*i)*C +: C];
                r_s0_y[i] <= s_axis_tdata[(2*i+1)*C +: C];
            end
        end
        if (stg_en[1]) begin
            r_s1_x <= r_s0_x;
            r_s1_y <= r_s0_y;
            r_a2_x <= n_a2_x;
            r_a2_y <= n_a2_y;
            r_a3_x <= n_a3_x;
            r_a3_y <= n_a3_y;
            r_ok1  <= n_ok1;
        end
        if (stg_en[2]) r_ok2 <= r_ok1;
        if (stg_en[3]) r_ok3 <= r_ok2;
        if (stg_en[4]) r_ok4 <= r_ok3;
        if (stg_en[5]) r_overlaps <= r_ok4 && ovl2 && ovl3;
    end

    always_comb begin
        pt_x[0] = r_x_min; pt_y[0] = r_y_max;
        pt_x[1] = r_x_max; pt_y[1] = r_y_max;
        pt_x[2] = r_x_min; pt_y[2] = r_y_min;
        pt_x[3] = r_x_max; pt_y[3] = r_y_min;
        for (int i = 0; i < 4; i++) begin
            pt_x[4+i] = r_s1_x[i];
            pt_y[4+i] = r_s1_y[i];
        end
    end

    assign span_en = '{prod: stg_en[2], dot: stg_en[3], span: stg_en[4]};

    rwo_axis_span #(.COORD_BITS(COORD_BITS)) u_axis_top (
        .i_clk     (i_clk),
        .i_en      (span_en),
        .i_px      (pt_x),
        .i_py      (pt_y),
        .i_ax      (r_a2_x),
        .i_ay      (r_a2_y),
        .o_overlap (ovl2)
    );

    rwo_axis_span #(.COORD_BITS(COORD_BITS)) u_axis_side (
        .i_clk     (i_clk),
        .i_en      (span_en),
        .i_px      (pt_x),
        .i_py      (pt_y),
        .i_ax      (r_a3_x),
        .i_ay      (r_a3_y),
        .o_overlap (ovl3)
    );

endmodule

// File: sim/rect_window_overlap_sat_tb.sv
// Self-checking stream testbench for the rectangle against window overlap test.
module rect_window_overlap_sat_tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CB = rwo_pkg::COORD_BITS_DEF;

    typedef logic signed [CB-1:0] t_coord;

    // corners in stream order, lt_x in the lowest bits
    typedef struct packed {
        t_coord rb_y;
        t_coord rb_x;
        t_coord lb_y;
        t_coord lb_x;
        t_coord rt_y;
        t_coord rt_x;
        t_coord lt_y;
        t_coord lt_x;
    } t_quad;

    logic              i_clk;
    logic              i_rst_n = 1'b0;
    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    // lt_x, lt_y, rt_x, rt_y, lb_x, lb_y, rb_x, rb_y
    logic [8*CB-1:0]   s_axis_tdata = '0;
    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    // overlaps, zero fill
    logic [7:0]        m_axis_tdata;
    logic              i_cfg_we = 1'b0;
    logic [rwo_pkg::CFG_IDX_W-1:0] i_cfg_idx = rwo_pkg::CFG_X_MIN;
    logic [CB-1:0]     i_cfg_data = '0;

    t_coord win_x_min = t_coord'(rwo_pkg::WIN_LO_RST);
    t_coord win_x_max = t_coord'(rwo_pkg::WIN_HI_RST);
    t_coord win_y_min = t_coord'(rwo_pkg::WIN_LO_RST);
    t_coord win_y_max = t_coord'(rwo_pkg::WIN_HI_RST);

    t_quad  pending_quads[$];
    bit     overlap_due[$];
    bit     item_sent = 1'b0;
    int     send_idle_pct = 0;
    int     recv_stall_pct = 0;
    bit     pressure_go = 1'b0;
    bit     recv_hold = 1'b0;
    int     fail_count = 0;

    rect_window_overlap_sat #(.COORD_BITS(CB)) uut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_idx     (i_cfg_idx),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        i_clk = 1'b0;
        #6;
        i_clk = 1'b1;
        #6;
    end

    // separating axes: both window edges, then two rectangle edges
    function automatic bit quad_hits_window(t_quad q);
        longint wx[4], wy[4], rx[4], ry[4], ax[4], ay[4];
        longint p, w_lo, w_hi, r_lo, r_hi;
        bit     hit;
        int     k, c;
        wx = '{win_x_min, win_x_max, win_x_min, win_x_max};
        wy = '{win_y_max, win_y_max, win_y_min, win_y_min};
        rx = '{q.lt_x, q.rt_x, q.lb_x, q.rb_x};
        ry = '{q.lt_y, q.rt_y, q.lb_y, q.rb_y};
        ax = '{longint'(win_x_max) - win_x_min, 0, rx[1] - rx[0], rx[1] - rx[3]};
        ay = '{0, longint'(win_y_max) - win_y_min, ry[1] - ry[0], ry[1] - ry[3]};
        hit = 1'b1;
        for (k = 0; k < 4; k++) begin
            if (ax[k] == 0 && ay[k] == 0) begin
                hit = 1'b0;
            end else begin
                w_lo = wx[0] * ax[k] + wy[0] * ay[k];
                w_hi = w_lo;
                r_lo = rx[0] * ax[k] + ry[0] * ay[k];
                r_hi = r_lo;
                for (c = 1; c < 4; c++) begin
                    p = wx[c] * ax[k] + wy[c] * ay[k];
                    if (p < w_lo) w_lo = p;
                    if (p > w_hi) w_hi = p;
                    p = rx[c] * ax[k] + ry[c] * ay[k];
                    if (p < r_lo) r_lo = p;
                    if (p > r_hi) r_hi = p;
                end
                if (w_hi < r_lo || r_hi < w_lo) hit = 1'b0;
            end
        end
        return hit;
    endfunction

    function automatic t_quad quad_of(int ltx, int lty, int rtx, int rty,
                                      int lbx, int lby, int rbx, int rby);
        t_quad q;
        q.lt_x = t_coord'(ltx);
        q.lt_y = t_coord'(lty);
        q.rt_x = t_coord'(rtx);
        q.rt_y = t_coord'(rty);
        q.lb_x = t_coord'(lbx);
        q.lb_y = t_coord'(lby);
        q.rb_x = t_coord'(rbx);
        q.rb_y = t_coord'(rby);
        return q;
    endfunction

    function automatic t_quad random_quad();
        t_quad q;
        int    r, cx, cy, ux, uy, vx, vy, k, xa, xb, ya, yb;
        r  = $urandom_range(99);
        cx = (int'(win_x_min) + int'(win_x_max)) / 2 + int'($urandom_range(24000)) - 12000;
        cy = (int'(win_y_min) + int'(win_y_max)) / 2 + int'($urandom_range(24000)) - 12000;
        ux = int'($urandom_range(16000)) - 8000;
        uy = (r < 12) ? 0 : int'($urandom_range(16000)) - 8000;
        k  = $urandom_range(6, 1);
        vx = -uy * k / 4;
        vy = ux * k / 4;
        q  = quad_of(cx - ux + vx, cy - uy + vy, cx + ux + vx, cy + uy + vy,
                     cx - ux - vx, cy - uy - vy, cx + ux - vx, cy + uy - vy);
        if (r >= 55 && r < 72) begin
            // hug a window edge to within one step
            xa = ($urandom_range(1) ? int'(win_x_min) : int'(win_x_max))
                 + int'($urandom_range(2)) - 1;
            ya = ($urandom_range(1) ? int'(win_y_min) : int'(win_y_max))
                 + int'($urandom_range(2)) - 1;
            xb = xa + int'($urandom_range(16000)) - 8000;
            yb = ya + int'($urandom_range(16000)) - 8000;
            q  = quad_of(xa, yb, xb, yb, xa, ya, xb, ya);
        end else if (r >= 72 && r < 82) begin
            if ($urandom_range(1)) begin
                q.rt_x = q.lt_x;
                q.rt_y = q.lt_y;
            end else begin
                q.rt_x = q.rb_x;
                q.rt_y = q.rb_y;
            end
        end else if (r >= 82) begin
            q = {$urandom, $urandom, $urandom, $urandom};
        end
        return q;
    endfunction

    task automatic report_mismatch(string msg);
        $display("mismatch at %0t: %s", $realtime, msg);
        fail_count++;
    endtask

    task automatic cfg_write(rwo_pkg::t_cfg_reg idx, t_coord val);
        @(negedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        case (idx)
            rwo_pkg::CFG_X_MIN: win_x_min = val;
            rwo_pkg::CFG_X_MAX: win_x_max = val;
            rwo_pkg::CFG_Y_MIN: win_y_min = val;
            rwo_pkg::CFG_Y_MAX: win_y_max = val;
            default: ;
        endcase
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic set_window(int x_lo, int x_hi, int y_lo, int y_hi);
        cfg_write(rwo_pkg::CFG_X_MIN, t_coord'(x_lo));
        cfg_write(rwo_pkg::CFG_X_MAX, t_coord'(x_hi));
        cfg_write(rwo_pkg::CFG_Y_MIN, t_coord'(y_lo));
        cfg_write(rwo_pkg::CFG_Y_MAX, t_coord'(y_hi));
    endtask

    task automatic wait_drained();
        while (pending_quads.size() != 0 || overlap_due.size() != 0) @(posedge i_clk);
        repeat (12) @(posedge i_clk);
    endtask

    // take items and results
    always @(posedge i_clk) begin
        item_sent <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) begin
                overlap_due.push_back(quad_hits_window(t_quad'(s_axis_tdata)));
                void'(pending_quads.pop_front());
            end
            if (m_axis_tvalid && m_axis_tready) begin
                if (overlap_due.size() == 0) begin
                    report_mismatch($sformatf("unexpected result %h", m_axis_tdata));
                end else if (m_axis_tdata !== {7'd0, overlap_due[0]}) begin
                    report_mismatch($sformatf("overlaps got %h want %h",
                                              m_axis_tdata, {7'd0, overlap_due[0]}));
                    void'(overlap_due.pop_front());
                end else begin
                    void'(overlap_due.pop_front());
                end
            end
        end
    end

    // offer the next item, holding any item not yet taken
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            s_axis_tvalid <= 1'b0;
        end else if (!s_axis_tvalid || item_sent) begin
            if (pending_quads.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= pending_quads[0];
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    always @(negedge i_clk) begin
        m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_stall_pct);
    end

    initial begin
        wait (pressure_go);
        recv_hold = 1'b1;
        repeat (300) @(posedge i_clk);
        recv_hold = 1'b0;
    end

    initial begin
        #2_400_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int ph, n;
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        pending_quads.push_back(quad_of(0, 0, 0, 0, 0, 0, 0, 0));
        pending_quads.push_back({8{16'h8000}});
        pending_quads.push_back({8{16'h7fff}});
        pending_quads.push_back({4{32'h5555aaaa}});
        pending_quads.push_back({4{32'haaaa5555}});
        pending_quads.push_back(quad_of(-4096, 4096, 4096, 4096, -4096, -4096, 4096, -4096));
        pending_quads.push_back(quad_of(4096, 4096, 8192, 4096, 4096, 0, 8192, 0));
        pending_quads.push_back(quad_of(4097, 4096, 8192, 4096, 4097, 0, 8192, 0));
        pending_quads.push_back(quad_of(0, 8192, 4096, 8192, 0, 4096, 4096, 4096));
        pending_quads.push_back(quad_of(0, -4097, 4096, -4097, 0, -8192, 4096, -8192));
        pending_quads.push_back(quad_of(-32768, 32767, 32767, 32767,
                                        -32768, -32768, 32767, -32768));
        pending_quads.push_back(quad_of(3500, 6000, 6000, 8500, 6000, 3500, 8500, 6000));
        pending_quads.push_back(quad_of(3000, 5000, 5000, 7000, 5000, 3000, 7000, 5000));
        pending_quads.push_back(quad_of(100, 100, 100, 100, -100, -100, 200, -200));
        pending_quads.push_back(quad_of(-100, 100, 100, 100, -100, -100, 100, 100));
        pending_quads.push_back(quad_of(-10, 10, 10, 10, -10, -10, 10, -10));
        pending_quads.push_back(quad_of(4096, -4096, -4096, -4096, 4096, 4096, -4096, 4096));
        pending_quads.push_back(quad_of(-20000, 0, 0, 20000, 0, -20000, 20000, 0));

        for (ph = 0; ph < 8; ph++) begin
            if (ph != 0) wait_drained();
            case (ph)
                1: set_window(-32768, 32767, -32768, 32767);
                2: set_window(4096, -4096, 2000, -3000);
                3: set_window(1000, 1000, -4096, 4096);
                4: set_window(int'($urandom_range(16000)) - 12000,
                              int'($urandom_range(16000)) - 4000,
                              int'($urandom_range(16000)) - 12000,
                              int'($urandom_range(16000)) - 4000);
                5: set_window(32767, -32768, 32767, -32768);
                6: set_window(0, 1, -1, 0);
                7: set_window(int'($urandom_range(65535)), int'($urandom_range(65535)),
                              int'($urandom_range(65535)), int'($urandom_range(65535)));
                default: ;
            endcase
            case (ph % 4)
                0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                1: begin send_idle_pct = 57; recv_stall_pct = 0;  end
                2: begin send_idle_pct = 0;  recv_stall_pct = 57; end
                default: begin send_idle_pct = 22; recv_stall_pct = 22; end
            endcase
            for (n = 0; n < 225; n++) pending_quads.push_back(random_quad());
            if (ph == 0) pressure_go = 1'b1;
        end
        wait_drained();
        repeat (20) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end

endmodule
